FILE: hdl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg - shared types and constants for the pulse width capture block
// Phase codes, register indexes, reset values and the item/result records.
// ----------------------------------------------------------------------------
package pwc_pkg;

  // Measurement phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SKIP_H = 3'd1,
    PH_SKIP_L = 3'd2,
    PH_MEAS_H = 3'd3,
    PH_MEAS_L = 3'd4
  } phase_t;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int WIDTH_W     = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_TIMEOUT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INJ_HIGH_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INJ_LOW_TIMEOUT  = 2'd2;

  // Register reset values, in 8 us ticks
  localparam logic [CFG_DATA_W-1:0] SPEED_TIMEOUT_RST    = 16'd5000;
  localparam logic [CFG_DATA_W-1:0] INJ_HIGH_TIMEOUT_RST = 16'd4000;
  localparam logic [CFG_DATA_W-1:0] INJ_LOW_TIMEOUT_RST  = 16'd15000;

  // Item kinds and channel codes
  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_START    = 1'b1;
  localparam logic CHAN_SPEED    = 1'b0;
  localparam logic CHAN_INJECTOR = 1'b1;

  // Largest reportable width
  localparam logic [WIDTH_W-1:0] WIDTH_SAT = 16'hFFFF;

  typedef struct packed {
    logic kind;
    logic channel;
    logic speed_level;
    logic injector_level;
  } item_t;

  typedef struct packed {
    logic               measured_channel;
    logic [WIDTH_W-1:0] high_width;
    logic [WIDTH_W-1:0] low_width;
  } result_t;

endpackage

FILE: hdl/pwc_if.sv
// ----------------------------------------------------------------------------
// pwc_if - stream interfaces of the pulse width capture block
// Valid/ready channels for input items and for measurement results.
// ----------------------------------------------------------------------------

// Input items: timer ticks with sampled levels, or start commands
interface pwc_item_if;
  logic valid;
  logic ready;
  logic kind;
  logic channel;
  logic speed_level;
  logic injector_level;

  modport source (output valid, output kind, output channel, output speed_level,
                  output injector_level, input ready);
  modport sink   (input valid, input kind, input channel, input speed_level,
                  input injector_level, output ready);
endinterface

// Results: one per finished measurement
interface pwc_result_if;
  logic        valid;
  logic        ready;
  logic        measured_channel;
  logic [15:0] high_width;
  logic [15:0] low_width;

  modport source (output valid, output measured_channel, output high_width,
                  output low_width, input ready);
  modport sink   (input valid, input measured_channel, input high_width,
                  input low_width, output ready);
endinterface

FILE: hdl/pulse_width_capture.sv
// ----------------------------------------------------------------------------
// pulse_width_capture - pulse width measurement with timeout
// Measures high and low widths of the speed or injector input in timer ticks.
// ----------------------------------------------------------------------------
// Path: the tick transaction that ends the last phase passes the input
//   register, then the phase logic into the output register.
// Throughput: one item per cycle; the only stall is a result held in the
//   output register while the downstream side is not ready.
// Reset (rst, synchronous): phase idle, counters cleared, timeouts to defaults.
module pulse_width_capture #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  pwc_item_if.sink                           item,
  pwc_result_if.source                       result,
  input  logic                               cfg_we,
  input  logic [pwc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > pwc_pkg::WIDTH_W) ? COUNT_WIDTH : pwc_pkg::WIDTH_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [pwc_pkg::CFG_DATA_W-1:0] speed_timeout;
  logic [pwc_pkg::CFG_DATA_W-1:0] injector_high_timeout;
  logic [pwc_pkg::CFG_DATA_W-1:0] injector_low_timeout;

  // Input stage
  logic           s1_valid;
  pwc_pkg::item_t s1_item;
  logic           s1_fire;
  logic           out_space;

  // Measurement state
  pwc_pkg::phase_t          phase, phase_next;
  logic                     active_channel, active_channel_next;
  logic [COUNT_WIDTH-1:0]   tick_count, tick_count_next;
  logic [pwc_pkg::WIDTH_W-1:0] captured_width, captured_width_next;

  // Phase datapath
  logic                        phase_live;
  logic                        high_phase;
  logic                        level;
  logic                        level_match;
  logic [pwc_pkg::CFG_DATA_W-1:0] timeout;
  logic [COUNT_WIDTH-1:0]      count_inc;
  logic [COUNT_WIDTH-1:0]      width_cnt;
  logic [CMP_W-1:0]            width_ext;
  logic [pwc_pkg::WIDTH_W-1:0] width;
  logic                        phase_done;
  logic                        is_tick;

  // Result
  logic             res_load;
  pwc_pkg::result_t res_data;

  // Configuration writes; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_timeout         <= pwc_pkg::SPEED_TIMEOUT_RST;
      injector_high_timeout <= pwc_pkg::INJ_HIGH_TIMEOUT_RST;
      injector_low_timeout  <= pwc_pkg::INJ_LOW_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwc_pkg::REG_SPEED_TIMEOUT:    speed_timeout         <= cfg_data;
        pwc_pkg::REG_INJ_HIGH_TIMEOUT: injector_high_timeout <= cfg_data;
        pwc_pkg::REG_INJ_LOW_TIMEOUT:  injector_low_timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_fire    = s1_valid && out_space;
  assign item.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= '{kind: item.kind, channel: item.channel,
                   speed_level: item.speed_level, injector_level: item.injector_level};
    end
  end

  // Phase decode
  always_comb begin
    unique case (phase)
      pwc_pkg::PH_SKIP_H, pwc_pkg::PH_SKIP_L,
      pwc_pkg::PH_MEAS_H, pwc_pkg::PH_MEAS_L: phase_live = 1'b1;
      default:                                phase_live = 1'b0;
    endcase
  end

  assign high_phase = (phase == pwc_pkg::PH_SKIP_H) || (phase == pwc_pkg::PH_MEAS_H);
  assign level      = (active_channel == pwc_pkg::CHAN_INJECTOR) ? s1_item.injector_level
                                                                 : s1_item.speed_level;
  assign level_match = (level == high_phase);
  assign timeout    = (active_channel == pwc_pkg::CHAN_SPEED) ? speed_timeout :
                      high_phase ? injector_high_timeout : injector_low_timeout;

  // Saturating tick count and end-of-phase test
  assign count_inc  = (tick_count != COUNT_MAX) ? tick_count + 1'b1 : tick_count;
  assign phase_done = !level_match
                   || (CMP_W'(count_inc) > CMP_W'(timeout))
                   || (count_inc == COUNT_MAX);
  assign width_cnt  = level_match ? count_inc : tick_count;
  assign width_ext  = CMP_W'(width_cnt);
  assign width      = (width_ext > CMP_W'(pwc_pkg::WIDTH_SAT)) ? pwc_pkg::WIDTH_SAT
                                                              : width_ext[pwc_pkg::WIDTH_W-1:0];
  assign is_tick    = (s1_item.kind == pwc_pkg::KIND_TICK);

  // Next state
  always_comb begin
    phase_next          = phase;
    active_channel_next = active_channel;
    tick_count_next     = tick_count;
    captured_width_next = captured_width;
    if (s1_fire) begin
      if (!is_tick) begin
        // start is ignored while a measurement runs
        if (!phase_live) begin
          phase_next          = pwc_pkg::PH_SKIP_H;
          active_channel_next = s1_item.channel;
          tick_count_next     = '0;
          captured_width_next = '0;
        end
      end else if (!phase_live) begin
        phase_next = pwc_pkg::PH_IDLE;
      end else if (!phase_done) begin
        tick_count_next = count_inc;
      end else begin
        tick_count_next = '0;
        unique case (phase)
          pwc_pkg::PH_SKIP_H: begin
            phase_next = (active_channel == pwc_pkg::CHAN_SPEED) ? pwc_pkg::PH_MEAS_L
                                                                 : pwc_pkg::PH_SKIP_L;
          end
          pwc_pkg::PH_SKIP_L: begin
            phase_next = pwc_pkg::PH_MEAS_H;
          end
          pwc_pkg::PH_MEAS_H: begin
            if (active_channel == pwc_pkg::CHAN_SPEED) begin
              phase_next = pwc_pkg::PH_IDLE;
            end else begin
              captured_width_next = width;
              phase_next          = pwc_pkg::PH_MEAS_L;
            end
          end
          pwc_pkg::PH_MEAS_L: begin
            if (active_channel == pwc_pkg::CHAN_SPEED) begin
              captured_width_next = width;
              phase_next          = pwc_pkg::PH_MEAS_H;
            end else begin
              phase_next = pwc_pkg::PH_IDLE;
            end
          end
          default: phase_next = pwc_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Result on the end of the final phase
  always_comb begin
    res_load = s1_fire && is_tick && phase_live && phase_done &&
               (((phase == pwc_pkg::PH_MEAS_H) && (active_channel == pwc_pkg::CHAN_SPEED)) ||
                ((phase == pwc_pkg::PH_MEAS_L) && (active_channel == pwc_pkg::CHAN_INJECTOR)));
    res_data.measured_channel = active_channel;
    if (active_channel == pwc_pkg::CHAN_SPEED) begin
      res_data.high_width = width;
      res_data.low_width  = captured_width;
    end else begin
      res_data.high_width = captured_width;
      res_data.low_width  = width;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pwc_pkg::PH_IDLE;
      active_channel <= pwc_pkg::CHAN_SPEED;
      tick_count     <= '0;
      captured_width <= '0;
    end else begin
      phase          <= phase_next;
      active_channel <= active_channel_next;
      tick_count     <= tick_count_next;
      captured_width <= captured_width_next;
    end
  end

  // Output register
  pwc_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (res_load),
    .data   (res_data),
    .space  (out_space),
    .result (result)
  );

endmodule

FILE: hdl/pwc_out_reg.sv
// ----------------------------------------------------------------------------
// pwc_out_reg - result output register
// Holds one finished result until the downstream side takes the transaction.
// ----------------------------------------------------------------------------
module pwc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pwc_pkg::result_t data,
  output logic             space,
  pwc_result_if.source     result
);

  logic             valid_q;
  pwc_pkg::result_t data_q;

  // Room for a new result when empty or when the current one leaves now
  assign space = !valid_q || result.ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (result.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= data;
    end
  end

  assign result.valid            = valid_q;
  assign result.measured_channel = data_q.measured_channel;
  assign result.high_width       = data_q.high_width;
  assign result.low_width        = data_q.low_width;

endmodule

FILE: hdl/pwc_checker.sv
// ----------------------------------------------------------------------------
// pwc_checker - port-level checks for pulse_width_capture
// Watches the item and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
module pwc_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        item_kind,
  input logic        result_valid,
  input logic        result_ready,
  input logic        result_measured_channel,
  input logic [15:0] result_high_width,
  input logic [15:0] result_low_width
);

  // A new result follows an accepted tick transaction through the input and output registers
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(item_valid && item_ready && (item_kind == pwc_pkg::KIND_TICK), 2))
    else $error("result appeared without a tick transaction two cycles earlier");

  // Input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("item channel stalled while result channel is free");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(result_measured_channel) &&
       $stable(result_high_width) && $stable(result_low_width)))
    else $error("stalled result dropped or changed");

  // Reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && item_ready))
    else $error("block not empty after reset");

endmodule

bind pulse_width_capture pwc_checker u_pwc_checker (
  .clk                     (clk),
  .rst                     (rst),
  .item_valid              (item.valid),
  .item_ready              (item.ready),
  .item_kind               (item.kind),
  .result_valid            (result.valid),
  .result_ready            (result.ready),
  .result_measured_channel (result.measured_channel),
  .result_high_width       (result.high_width),
  .result_low_width        (result.low_width)
);

FILE: tb/sv/pulse_width_capture_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_width_capture_tb - self-checking bench for the pulse width capture block
// Drives start and tick transactions with random gaps and random result
// backpressure. A behavioral predictor tracks the measurement phases and the
// expected widths. Each result is checked field by field against the oldest
// expected measurement. Timeout settings are swept from zero to the largest
// legal value between test phases.
// ----------------------------------------------------------------------------
module pulse_width_capture_tb;

  localparam int CNT_W       = 16;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;
  localparam logic [pwc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // Directed row: item, plus an expected result typed in where it is obvious
  typedef struct packed {
    pwc_pkg::item_t   it;
    logic             typed;
    pwc_pkg::result_t res;
  } dir_row_t;

  localparam pwc_pkg::result_t NO_RES = '0;

  logic clk;
  logic rst;
  logic                            cfg_we;
  logic [pwc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pwc_pkg::CFG_DATA_W-1:0]  cfg_data;

  pwc_item_if   item_ch ();
  pwc_result_if result_ch ();

  pulse_width_capture i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and its copy of the timeout registers
  pwc_pkg::phase_t                cap_phase;
  logic                           cap_chan;
  logic [CNT_W-1:0]               cap_count;
  logic [pwc_pkg::WIDTH_W-1:0]    cap_held;
  logic [pwc_pkg::CFG_DATA_W-1:0] to_speed;
  logic [pwc_pkg::CFG_DATA_W-1:0] to_inj_high;
  logic [pwc_pkg::CFG_DATA_W-1:0] to_inj_low;

  pwc_pkg::result_t pending_widths [$];

  int cycles      = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_speed     = 0;
  int n_injector  = 0;
  int n_err       = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_left    = 0;
  bit hold_req      = 1'b0;

  // Directed sequence at reset timeouts: idle tick, start while busy,
  // a speed and an injector measurement, then all-zero widths
  dir_row_t dir_tab [0:23] = '{
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_START, pwc_pkg::CHAN_SPEED,    1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_START, pwc_pkg::CHAN_INJECTOR, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b0}, 1'b1,
      '{pwc_pkg::CHAN_SPEED, 16'd3, 16'd2}},
    '{'{pwc_pkg::KIND_START, pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b0, 1'b1}, 1'b1,
      '{pwc_pkg::CHAN_INJECTOR, 16'd1, 16'd2}},
    '{'{pwc_pkg::KIND_START, pwc_pkg::CHAN_SPEED,    1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b1}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_INJECTOR, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{pwc_pkg::KIND_TICK,  pwc_pkg::CHAN_SPEED,    1'b0, 1'b1}, 1'b1,
      '{pwc_pkg::CHAN_SPEED, 16'd0, 16'd0}}
  };

  // Clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Predictor: one accepted transaction in, at most one measurement out
  task automatic predict_widths(input pwc_pkg::item_t it, output bit got,
                                output pwc_pkg::result_t res);
    logic                           lvl;
    logic                           want;
    logic [pwc_pkg::CFG_DATA_W-1:0] limit;
    logic                           ended;
    logic [pwc_pkg::WIDTH_W-1:0]    w;
    got = 1'b0;
    res = NO_RES;
    if (it.kind == pwc_pkg::KIND_START) begin
      // start while busy is dropped
      if (cap_phase == pwc_pkg::PH_IDLE) begin
        cap_chan  = it.channel;
        cap_phase = pwc_pkg::PH_SKIP_H;
        cap_count = '0;
        cap_held  = '0;
      end
      return;
    end
    if (cap_phase == pwc_pkg::PH_IDLE) return;

    lvl   = (cap_chan == pwc_pkg::CHAN_INJECTOR) ? it.injector_level : it.speed_level;
    want  = (cap_phase == pwc_pkg::PH_SKIP_H || cap_phase == pwc_pkg::PH_MEAS_H);
    limit = (cap_chan == pwc_pkg::CHAN_SPEED) ? to_speed : (want ? to_inj_high : to_inj_low);
    ended = (lvl != want);
    if (!ended) begin
      if (cap_count != {CNT_W{1'b1}}) cap_count++;
      ended = (cap_count > limit) || (cap_count == {CNT_W{1'b1}});
    end
    if (!ended) return;

    w = cap_count;
    cap_count = '0;
    if (cap_chan == pwc_pkg::CHAN_SPEED) begin
      case (cap_phase)
        pwc_pkg::PH_SKIP_H: cap_phase = pwc_pkg::PH_MEAS_L;
        pwc_pkg::PH_MEAS_L: begin
          cap_held  = w;
          cap_phase = pwc_pkg::PH_MEAS_H;
        end
        default: begin
          cap_phase = pwc_pkg::PH_IDLE;
          got = 1'b1;
          res = '{pwc_pkg::CHAN_SPEED, w, cap_held};
        end
      endcase
    end else begin
      case (cap_phase)
        pwc_pkg::PH_SKIP_H: cap_phase = pwc_pkg::PH_SKIP_L;
        pwc_pkg::PH_SKIP_L: cap_phase = pwc_pkg::PH_MEAS_H;
        pwc_pkg::PH_MEAS_H: begin
          cap_held  = w;
          cap_phase = pwc_pkg::PH_MEAS_L;
        end
        default: begin
          cap_phase = pwc_pkg::PH_IDLE;
          got = 1'b1;
          res = '{pwc_pkg::CHAN_INJECTOR, cap_held, w};
        end
      endcase
    end
  endtask

  // Offer one transaction, return at the edge where it is taken
  task automatic send_item(input pwc_pkg::item_t it);
    int gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.kind           <= it.kind;
    item_ch.channel        <= it.channel;
    item_ch.speed_level    <= it.speed_level;
    item_ch.injector_level <= it.injector_level;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    n_items++;
  endtask

  task automatic apply_item(input pwc_pkg::item_t it);
    bit               got;
    pwc_pkg::result_t res;
    send_item(it);
    predict_widths(it, got, res);
    if (got) pending_widths.push_back(res);
  endtask

  // Sender pause: wait for every measurement, then let the pipeline empty
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_widths.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One register write; caller lowers the write enable afterwards
  task automatic cfg_write(input logic [pwc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pwc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      pwc_pkg::REG_SPEED_TIMEOUT:    to_speed    = data;
      pwc_pkg::REG_INJ_HIGH_TIMEOUT: to_inj_high = data;
      pwc_pkg::REG_INJ_LOW_TIMEOUT:  to_inj_low  = data;
      default: ;
    endcase
  endtask

  task automatic set_timeouts(input logic [pwc_pkg::CFG_DATA_W-1:0] s,
                              input logic [pwc_pkg::CFG_DATA_W-1:0] h,
                              input logic [pwc_pkg::CFG_DATA_W-1:0] l);
    cfg_write(pwc_pkg::REG_SPEED_TIMEOUT, s);
    cfg_write(pwc_pkg::REG_INJ_HIGH_TIMEOUT, h);
    cfg_write(pwc_pkg::REG_INJ_LOW_TIMEOUT, l);
  endtask

  // Well-formed measurement: optional noise, a start, then level runs on the
  // active channel until the measurement completes
  task automatic run_measurement();
    pwc_pkg::item_t it;
    logic           lvl;
    int             run_len;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        it = 4'($urandom_range(0, 15));
        apply_item(it);
      end
    end
    it = 4'($urandom_range(0, 15));
    it.kind = pwc_pkg::KIND_START;
    apply_item(it);
    lvl = 1'($urandom_range(0, 1));
    while (cap_phase != pwc_pkg::PH_IDLE) begin
      run_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 30);
      for (int k = 0; k < run_len && cap_phase != pwc_pkg::PH_IDLE; k++) begin
        it = 4'($urandom_range(0, 15));
        it.kind = ($urandom_range(0, 39) == 0) ? pwc_pkg::KIND_START : pwc_pkg::KIND_TICK;
        if (cap_chan == pwc_pkg::CHAN_INJECTOR) it.injector_level = lvl;
        else it.speed_level = lvl;
        apply_item(it);
      end
      lvl = ~lvl;
    end
  endtask

  task automatic random_phase(input int n);
    int first;
    first = n_items;
    while (n_items - first < n) run_measurement();
  endtask

  // Result side: checks each accepted result and drives ready
  always @(posedge clk) begin : sink_side
    pwc_pkg::result_t want_res;
    int               gap;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        n_results++;
        if (result_ch.measured_channel === pwc_pkg::CHAN_INJECTOR) n_injector++;
        else n_speed++;
        if (pending_widths.size() == 0) begin
          $error("unexpected result: measured_channel %0d high_width %0d low_width %0d",
                 result_ch.measured_channel, result_ch.high_width, result_ch.low_width);
          n_err++;
        end else begin
          want_res = pending_widths.pop_front();
          if (result_ch.measured_channel !== want_res.measured_channel) begin
            $error("measured_channel: expected %0d, actual %0d",
                   want_res.measured_channel, result_ch.measured_channel);
            n_err++;
          end
          if (result_ch.high_width !== want_res.high_width) begin
            $error("high_width: expected %0d, actual %0d",
                   want_res.high_width, result_ch.high_width);
            n_err++;
          end
          if (result_ch.low_width !== want_res.low_width) begin
            $error("low_width: expected %0d, actual %0d",
                   want_res.low_width, result_ch.low_width);
            n_err++;
          end
        end
      end

      // next ready: long hold on request, else random stalls
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap(sink_idle_pct);
        if (gap > 0) begin
          stall_left = gap - 1;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Main sequence
  initial begin
    bit               got;
    pwc_pkg::result_t res;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = pwc_pkg::REG_SPEED_TIMEOUT;
    cfg_data  = '0;
    item_ch.valid          = 1'b0;
    item_ch.kind           = pwc_pkg::KIND_TICK;
    item_ch.channel        = pwc_pkg::CHAN_SPEED;
    item_ch.speed_level    = 1'b0;
    item_ch.injector_level = 1'b0;

    cap_phase   = pwc_pkg::PH_IDLE;
    cap_chan    = pwc_pkg::CHAN_SPEED;
    cap_count   = '0;
    cap_held    = '0;
    to_speed    = pwc_pkg::SPEED_TIMEOUT_RST;
    to_inj_high = pwc_pkg::INJ_HIGH_TIMEOUT_RST;
    to_inj_low  = pwc_pkg::INJ_LOW_TIMEOUT_RST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table at reset timeouts
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].it);
      predict_widths(dir_tab[i].it, got, res);
      if (dir_tab[i].typed) pending_widths.push_back(dir_tab[i].res);
      else if (got) pending_widths.push_back(res);
    end
    settle();

    // Timeout zero everywhere
    set_timeouts('0, '0, '0);
    cfg_we <= 1'b0;
    src_idle_pct  = 30;
    sink_idle_pct = 30;
    random_phase(200);
    settle();

    // Timeout one, with a long result hold while the sender keeps offering
    set_timeouts(16'd1, 16'd1, 16'd1);
    cfg_we <= 1'b0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req = 1'b1;
    random_phase(200);
    settle();

    // Small timeouts, so phases often end on a timeout
    set_timeouts(16'd3, 16'd5, 16'd7);
    cfg_we <= 1'b0;
    src_idle_pct  = 25;
    sink_idle_pct = 25;
    random_phase(250);
    settle();

    // Largest legal timeouts, no idling on either side
    set_timeouts(16'd65534, 16'd65534, 16'd65534);
    cfg_we <= 1'b0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_phase(250);
    settle();

    // Mixed timeouts; a write to the unused index must change nothing
    set_timeouts(16'd12, 16'd2, 16'd20);
    cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    src_idle_pct  = 40;
    sink_idle_pct = 40;
    random_phase(250);
    settle();
    repeat (20) @(posedge clk);

    $display("Run covered %0d input transactions and %0d results (%0d speed, %0d injector)",
             n_items, n_results, n_speed, n_injector);
    $display("Timeouts swept from zero through small values up to 65534");
    if (n_err == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
